FILE: sv/tlg_pkg.sv
package tlg_pkg;

  localparam int COLS = 64;
  localparam int ROWS = 64;

  localparam int CW = $clog2(COLS);
  localparam int RW = $clog2(ROWS);

  localparam logic [8:0]  COLS_LIM = 9'(COLS);
  localparam logic [8:0]  ROWS_LIM = 9'(ROWS);
  localparam logic [RW:0] ROWS_W   = (RW + 1)'(ROWS);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

  localparam logic [3:0] SURVIVE_LO = 4'd2;
  localparam logic [3:0] BIRTH_CNT  = 4'd3;

  localparam logic [1:0] CMD_SET  = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [7:0] col;
    logic signed [7:0] row;
  } in_t;

  typedef struct packed {
    logic alive;
    logic in_range;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_SP0,
    ST_SP1,
    ST_SWEEP,
    ST_FIN
  } state_t;

endpackage

FILE: sv/toroidal_life_grid_engine_unit.sv
// channel   | valid     | stall     | payload
// input     | in_valid  | in_stall  | in_data  (cmd, col, row)
// output    | out_valid | out_stall | out_data (alive, in_range)
//
// set and read commands pass through the access state before finishing, unknown ones go straight to finish
// a step loads the last row and row 0 first, then sweeps: one grid row is read and one written per cycle
// through the grid ram's read and write ports, next rows computed by one shared row unit
// reset clears per-row valid flags at once; no clearing pass is needed
// a finished result waits in the output register; the next command is taken
// meanwhile and holds its own result until the output register is free
module toroidal_life_grid_engine_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  tlg_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tlg_pkg::out_t out_data
);
  import tlg_pkg::*;

  state_t state, state_next;

  logic [1:0]      cmd_q;
  logic [CW-1:0]   col_q;
  logic [RW-1:0]   row_q;
  logic            ok_q;
  out_t            res;
  logic [RW-1:0]   w;
  logic [COLS-1:0] prev_row;
  logic [COLS-1:0] cur_row;
  logic [COLS-1:0] row0_save;
  logic [ROWS-1:0] row_valid;
  logic            rvalid;

  logic            we;
  logic [RW-1:0]   waddr;
  logic [COLS-1:0] wdata;
  logic [RW-1:0]   raddr;
  logic [COLS-1:0] rdata;
  logic [COLS-1:0] rd_row;
  logic [COLS-1:0] nxt_row;
  logic [COLS-1:0] new_row;
  logic [COLS-1:0] set_mask;
  logic [RW:0]     w_plus2;
  logic            accept;
  logic            on_grid;
  logic            out_free;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign on_grid  = !in_data.col[7] && ({1'b0, in_data.col} < COLS_LIM)
                 && !in_data.row[7] && ({1'b0, in_data.row} < ROWS_LIM);
  assign rd_row   = rdata & {COLS{rvalid}};
  assign set_mask = COLS'(1) << col_q;
  assign nxt_row  = (w == ROW_LAST) ? row0_save : rd_row;
  assign w_plus2  = {1'b0, w} + (RW + 1)'(2);

  tlg_ram #(
    .WIDTH(COLS),
    .DEPTH(ROWS)
  ) u_grid (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  tlg_row_unit u_row (
    .up (prev_row),
    .mid(cur_row),
    .dn (nxt_row),
    .nxt(new_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = row_q;
    wdata      = rd_row | set_mask;
    raddr      = in_data.row[RW-1:0];
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.cmd)
            CMD_SET, CMD_READ: state_next = ST_ACC;
            CMD_STEP: begin
              raddr      = ROW_LAST;
              state_next = ST_SP0;
            end
            default: state_next = ST_FIN;
          endcase
        end
      end
      ST_ACC: begin
        we         = (cmd_q == CMD_SET) && ok_q;
        state_next = ST_FIN;
      end
      ST_SP0: begin
        raddr      = '0;
        state_next = ST_SP1;
      end
      ST_SP1: begin
        raddr      = RW'(1);
        state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        we    = 1'b1;
        waddr = w;
        wdata = new_row;
        raddr = RW'((w_plus2 >= ROWS_W) ? (w_plus2 - ROWS_W) : w_plus2);
        if (w == ROW_LAST) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // per-row valid flags stand in for a cleared grid
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rvalid    <= 1'b0;
    end else begin
      if (we) begin
        row_valid[waddr] <= 1'b1;
      end
      rvalid <= row_valid[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w <= '0;
    end else if (state == ST_SP1) begin
      w <= '0;
    end else if (state == ST_SWEEP) begin
      w <= w + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q        <= in_data.cmd;
      col_q        <= in_data.col[CW-1:0];
      row_q        <= in_data.row[RW-1:0];
      ok_q         <= on_grid;
      res.alive    <= 1'b0;
      res.in_range <= (in_data.cmd == CMD_STEP)
                   || ((in_data.cmd inside {CMD_SET, CMD_READ}) && on_grid);
    end else if (state == ST_ACC) begin
      res.alive <= (cmd_q == CMD_READ) && ok_q && rd_row[col_q];
    end
    if (state == ST_SP0) begin
      prev_row <= rd_row;
    end else if (state == ST_SP1) begin
      cur_row   <= rd_row;
      row0_save <= rd_row;
    end else if (state == ST_SWEEP) begin
      prev_row <= cur_row;
      cur_row  <= nxt_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_data <= res;
    end
  end

`ifndef SYNTH
  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && w == ROW_LAST) |=> state == ST_FIN)
    else $error("sweep did not finish after last row");

  a_step_start: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.cmd == CMD_STEP) |=> state == ST_SP0)
    else $error("step transfer did not start sweep");

  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("result not presented on finish");

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == ST_ACC || state == ST_SWEEP))
    else $error("grid write outside set or sweep");

  a_sweep_raddr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (raddr != waddr))
    else $error("sweep reads the row it writes");
`endif

endmodule

FILE: sv/tlg_ram.sv
module tlg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/tlg_row_unit.sv
module tlg_row_unit (
  input  logic [tlg_pkg::COLS-1:0] up,
  input  logic [tlg_pkg::COLS-1:0] mid,
  input  logic [tlg_pkg::COLS-1:0] dn,
  output logic [tlg_pkg::COLS-1:0] nxt
);
  import tlg_pkg::*;

  for (genvar c = 0; c < COLS; c++) begin : g_cell
    localparam int L = (c == 0) ? COLS - 1 : c - 1;
    localparam int R = (c == COLS - 1) ? 0 : c + 1;
    logic [3:0] count;

    assign count = 4'(up[L]) + 4'(up[c]) + 4'(up[R]) + 4'(mid[L]) + 4'(mid[R])
                 + 4'(dn[L]) + 4'(dn[c]) + 4'(dn[R]);
    assign nxt[c] = mid[c] ? (count == SURVIVE_LO || count == BIRTH_CNT)
                           : (count == BIRTH_CNT);
  end

endmodule

FILE: tb/toroidal_life_grid_engine_unit_tb.sv
module toroidal_life_grid_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlg_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int CALM_FROM = 420;
  localparam int CALM_TO = 520;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  logic [COLS-1:0] life_gen [ROWS];
  out_t cell_replies [$];
  in_t tab_item [$];
  bit tab_typed [$];
  out_t tab_want [$];

  int sent_cnt = 0;
  int mismatches = 0;
  int cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int bx = 0;
  int by = 0;

  toroidal_life_grid_engine_unit u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit calm();
    return sent_cnt >= CALM_FROM && sent_cnt < CALM_TO;
  endfunction

  // next generation, B3/S23 on the wrapped grid
  function automatic void life_advance();
    logic [COLS-1:0] nxt [ROWS];
    int cnt;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        cnt = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              cnt += life_gen[(r + dr + ROWS) % ROWS][(c + dc + COLS) % COLS];
            end
          end
        end
        nxt[r][c] = life_gen[r][c] ? (cnt == 2 || cnt == 3) : (cnt == 3);
      end
    end
    for (int r = 0; r < ROWS; r++) begin
      life_gen[r] = nxt[r];
    end
  endfunction

  function automatic void grid_apply(input in_t it, output out_t res);
    int c;
    int r;
    bit on_grid;
    c = int'(it.col);
    r = int'(it.row);
    on_grid = c >= 0 && c < COLS && r >= 0 && r < ROWS;
    res = '0;
    case (it.cmd)
      CMD_SET: begin
        if (on_grid) begin
          life_gen[r][c] = 1'b1;
          res.in_range = 1'b1;
        end
      end
      CMD_STEP: begin
        life_advance();
        res.in_range = 1'b1;
      end
      CMD_READ: begin
        if (on_grid) begin
          res.alive = life_gen[r][c];
          res.in_range = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_t make_random();
    in_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.col = 8'($urandom);
    it.row = 8'($urandom);
    if (pick < 40) begin
      it.cmd = CMD_SET;
      it.col = 8'((bx + $urandom_range(0, 6)) % COLS);
      it.row = 8'((by + $urandom_range(0, 6)) % ROWS);
    end else if (pick < 55) begin
      it.cmd = CMD_STEP;
    end else if (pick < 85) begin
      it.cmd = CMD_READ;
      if ($urandom_range(0, 1) == 1) begin
        it.col = 8'((bx + $urandom_range(0, 7)) % COLS);
        it.row = 8'((by + $urandom_range(0, 7)) % ROWS);
      end else begin
        it.col = 8'($urandom_range(0, COLS - 1));
        it.row = 8'($urandom_range(0, ROWS - 1));
      end
    end else begin
      it.cmd = 2'($urandom_range(0, 3));
    end
    return it;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input int col, input int row,
                         input bit typed, input logic alive, input logic in_range);
    in_t it;
    out_t want;
    it.cmd = cmd;
    it.col = 8'(col);
    it.row = 8'(row);
    want.alive = alive;
    want.in_range = in_range;
    tab_item.push_back(it);
    tab_typed.push_back(typed);
    tab_want.push_back(want);
  endtask

  task automatic offer(input in_t it, input bit typed, input out_t want);
    out_t pred;
    while (!calm() && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    grid_apply(it, pred);
    cell_replies.push_back(typed ? want : pred);
    sent_cnt++;
  endtask

  task automatic note_mismatch(input string what, input out_t exp, input out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected alive %0b in_range %0b, got alive %0b in_range %0b",
               $realtime, what, exp.alive, exp.in_range, got.alive, got.in_range);
    end
  endtask

  initial begin
    for (int r = 0; r < ROWS; r++) begin
      life_gen[r] = '0;
    end
    add_row(CMD_READ, 0, 0, 1'b1, 1'b0, 1'b1);
    add_row(CMD_READ, 63, 63, 1'b1, 1'b0, 1'b1);
    add_row(CMD_READ, -128, 0, 1'b1, 1'b0, 1'b0);
    add_row(CMD_READ, 0, 127, 1'b1, 1'b0, 1'b0);
    add_row(CMD_READ, 64, -1, 1'b1, 1'b0, 1'b0);
    add_row(CMD_SET, -1, 5, 1'b1, 1'b0, 1'b0);
    add_row(CMD_SET, 5, 64, 1'b1, 1'b0, 1'b0);
    add_row(CMD_NONE, 3, 3, 1'b1, 1'b0, 1'b0);
    add_row(CMD_STEP, -128, 127, 1'b1, 1'b0, 1'b1);
    add_row(CMD_READ, 3, 3, 1'b1, 1'b0, 1'b1);
    add_row(CMD_SET, 0, 0, 1'b1, 1'b0, 1'b1);
    add_row(CMD_SET, 0, 0, 1'b1, 1'b0, 1'b1);
    add_row(CMD_READ, 0, 0, 1'b1, 1'b1, 1'b1);
    // blinker wrapped across the column edge
    add_row(CMD_SET, 63, 0, 1'b1, 1'b0, 1'b1);
    add_row(CMD_SET, 1, 0, 1'b1, 1'b0, 1'b1);
    add_row(CMD_STEP, 127, -128, 1'b1, 1'b0, 1'b1);
    add_row(CMD_READ, 0, 63, 1'b0, 1'b0, 1'b0);
    add_row(CMD_READ, 0, 1, 1'b0, 1'b0, 1'b0);
    add_row(CMD_READ, 63, 0, 1'b0, 1'b0, 1'b0);
    add_row(CMD_STEP, 0, 0, 1'b1, 1'b0, 1'b1);
    add_row(CMD_READ, 1, 0, 1'b0, 1'b0, 1'b0);
    add_row(CMD_SET, 127, 127, 1'b1, 1'b0, 1'b0);
    add_row(CMD_READ, -1, -1, 1'b1, 1'b0, 1'b0);
    add_row(CMD_NONE, -128, -128, 1'b1, 1'b0, 1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < tab_item.size(); i++) begin
      offer(tab_item[i], tab_typed[i], tab_want[i]);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 30 == 0) begin
        bx = $urandom_range(0, COLS - 1);
        by = $urandom_range(0, ROWS - 1);
      end
      offer(make_random(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (cell_replies.size() != 0) @(posedge clk);
    repeat (ROWS + 16) @(posedge clk);
    while (cell_replies.size() != 0) begin
      note_mismatch("missing transfer", cell_replies.pop_front(), '0);
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  always @(posedge clk) begin
    out_t exp;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cell_replies.size() == 0) begin
          note_mismatch("unexpected transfer", '0, out_data);
        end else begin
          exp = cell_replies.pop_front();
          if (out_data.alive !== exp.alive || out_data.in_range !== exp.in_range) begin
            note_mismatch("result mismatch", exp, out_data);
          end
        end
      end
      // long hold-off so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && sent_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      out_stall <= hold_left > 0 || (!calm() && $urandom_range(0, 99) < 14);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
